// ===== hw/rtl/sbrl_pkg.sv =====
`default_nettype none

package sbrl_pkg;

  // Default sizes of the ring and of one pull.
  localparam int RING_DEPTH_DEF = 4096;
  localparam int MAX_PULL_DEF   = 64;

  // Fixed field widths.
  localparam int KIND_W = 2;
  localparam int BYTE_W = 8;
  localparam int SEQ_W  = 32;
  localparam int LEN_W  = 7;

  // Depth of the command queue between the front and the back.
  localparam int CMD_DEPTH = 4;

  typedef enum logic [KIND_W-1:0] {
    KIND_WRITE = 2'd0,
    KIND_PULL  = 2'd1,
    KIND_CLEAR = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_DATA
  } back_state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/sbrl_ram.sv =====
`default_nettype none

module sbrl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/sbrl_cmd_fifo.sv =====
`default_nettype none

module sbrl_cmd_fifo #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] din,
  output logic                  full,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] dout,
  output logic                  empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = slots[rd_ptr];

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= din;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/sbrl_front.sv =====
`default_nettype none

module sbrl_front #(
  parameter int RING_DEPTH = sbrl_pkg::RING_DEPTH_DEF,
  parameter int MAX_PULL   = sbrl_pkg::MAX_PULL_DEF,
  parameter int AW         = $clog2(RING_DEPTH),
  parameter int CMD_W      = 1 + sbrl_pkg::BYTE_W + AW + sbrl_pkg::LEN_W + sbrl_pkg::SEQ_W
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        push,
  output logic                             full,
  input  wire logic [sbrl_pkg::KIND_W-1:0] kind,
  input  wire logic [sbrl_pkg::BYTE_W-1:0] data_byte,
  input  wire logic [sbrl_pkg::SEQ_W-1:0]  from_seq,
  input  wire logic [sbrl_pkg::LEN_W-1:0]  max_len,
  output logic                             cmd_push,
  output logic      [CMD_W-1:0]            cmd_data,
  input  wire logic                        cmd_full
);

  localparam int BW    = $clog2(RING_DEPTH + 1);
  localparam int PW    = AW + 1;
  localparam int SEQ_W = sbrl_pkg::SEQ_W;
  localparam int LEN_W = sbrl_pkg::LEN_W;

  // Architectural state, kept current as items are accepted.
  logic [AW-1:0]    wpos;
  logic [SEQ_W-1:0] count;

  // Classified item waiting for a queue slot.
  logic                        a_vld;
  logic                        a_is_pull;
  logic [sbrl_pkg::BYTE_W-1:0] a_data;
  logic [AW-1:0]               a_pos;
  logic [SEQ_W-1:0]            a_start;
  logic [BW-1:0]               a_backlog;
  logic [LEN_W-1:0]            a_maxcap;

  logic             accept;
  logic             a_adv;
  logic             is_write;
  logic             is_pull;
  logic             is_clear;
  logic [SEQ_W-1:0] diff;
  logic             out_of_range;
  logic             total_gt;
  logic [SEQ_W-1:0] start_sel;
  logic [BW-1:0]    backlog_sel;
  logic [LEN_W-1:0] maxcap;
  logic [LEN_W-1:0] len;
  logic [SEQ_W-1:0] nseq;
  logic [PW-1:0]    pos_sum;
  logic [AW-1:0]    pos;

  assign full     = a_vld && cmd_full;
  assign accept   = push && !full;
  assign a_adv    = a_vld && !cmd_full;
  assign cmd_push = a_adv;

  assign is_write = (kind == sbrl_pkg::KIND_WRITE);
  assign is_pull  = (kind == sbrl_pkg::KIND_PULL);
  assign is_clear = (kind == sbrl_pkg::KIND_CLEAR);

  // Resume point: fall back to the oldest retained byte when out of range.
  assign diff         = count - from_seq;
  assign total_gt     = (count > SEQ_W'(RING_DEPTH));
  assign out_of_range = (from_seq == '0) || (from_seq > count) ||
                        (diff > SEQ_W'(RING_DEPTH));
  assign start_sel    = !out_of_range ? from_seq :
                        (total_gt ? count - SEQ_W'(RING_DEPTH) : '0);
  assign backlog_sel  = !out_of_range ? diff[BW-1:0] :
                        (total_gt ? BW'(RING_DEPTH) : count[BW-1:0]);
  assign maxcap       = (max_len > LEN_W'(MAX_PULL)) ? LEN_W'(MAX_PULL) : max_len;

  // Second half of the work, done on the held item.
  assign len     = (32'(a_backlog) < 32'(a_maxcap)) ? LEN_W'(a_backlog) : a_maxcap;
  assign nseq    = a_start + SEQ_W'(len);
  assign pos_sum = PW'(a_pos) + PW'(RING_DEPTH) - PW'(a_backlog);
  assign pos     = (pos_sum >= PW'(RING_DEPTH)) ? AW'(pos_sum - PW'(RING_DEPTH))
                                                : AW'(pos_sum);

  assign cmd_data = a_is_pull ? {1'b1, a_data, pos, len, nseq}
                              : {1'b0, a_data, a_pos, {LEN_W{1'b0}}, {SEQ_W{1'b0}}};

  always_ff @(posedge clk) begin
    if (rst) begin
      wpos  <= '0;
      count <= '0;
      a_vld <= 1'b0;
    end else begin
      if (accept && is_write) begin
        wpos  <= (wpos == AW'(RING_DEPTH - 1)) ? '0 : wpos + AW'(1);
        count <= count + SEQ_W'(1);
      end else if (accept && is_clear) begin
        wpos  <= '0;
        count <= '0;
      end
      if (accept && (is_write || is_pull)) begin
        a_vld <= 1'b1;
      end else if (a_adv) begin
        a_vld <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_is_pull <= is_pull;
      a_data    <= data_byte;
      a_pos     <= wpos;
      a_start   <= start_sel;
      a_backlog <= backlog_sel;
      a_maxcap  <= maxcap;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/sbrl_back.sv =====
`default_nettype none

module sbrl_back #(
  parameter int RING_DEPTH = sbrl_pkg::RING_DEPTH_DEF,
  parameter int AW         = $clog2(RING_DEPTH),
  parameter int CMD_W      = 1 + sbrl_pkg::BYTE_W + AW + sbrl_pkg::LEN_W + sbrl_pkg::SEQ_W
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cmd_empty,
  input  wire logic [CMD_W-1:0]            cmd_data,
  output logic                             cmd_pop,
  output logic                             ram_we,
  output logic      [AW-1:0]               ram_waddr,
  output logic      [sbrl_pkg::BYTE_W-1:0] ram_wdata,
  output logic                             ram_re,
  output logic      [AW-1:0]               ram_raddr,
  input  wire logic [sbrl_pkg::BYTE_W-1:0] ram_rdata,
  output logic                             empty,
  input  wire logic                        pop,
  output logic      [sbrl_pkg::BYTE_W-1:0] out_byte,
  output logic                             has_data,
  output logic                             last,
  output logic      [sbrl_pkg::SEQ_W-1:0]  after_seq
);

  localparam int BYTE_W = sbrl_pkg::BYTE_W;
  localparam int SEQ_W  = sbrl_pkg::SEQ_W;
  localparam int LEN_W  = sbrl_pkg::LEN_W;

  logic              c_is_pull;
  logic [BYTE_W-1:0] c_data;
  logic [AW-1:0]     c_pos;
  logic [LEN_W-1:0]  c_len;
  logic [SEQ_W-1:0]  c_nseq;

  sbrl_pkg::back_state_t state, state_next;

  logic [AW-1:0]     addr, addr_next;
  logic [LEN_W-1:0]  remaining, remaining_next;
  logic [SEQ_W-1:0]  nseq, nseq_next;
  logic              out_valid, out_valid_next;
  logic              load;
  logic [BYTE_W-1:0] load_byte;
  logic              load_has;
  logic              load_last;
  logic [SEQ_W-1:0]  load_nseq;
  logic              out_free;

  assign {c_is_pull, c_data, c_pos, c_len, c_nseq} = cmd_data;

  assign empty    = !out_valid;
  assign out_free = !out_valid || pop;

  always_comb begin
    state_next     = state;
    addr_next      = addr;
    remaining_next = remaining;
    nseq_next      = nseq;
    cmd_pop        = 1'b0;
    ram_we         = 1'b0;
    ram_waddr      = c_pos;
    ram_wdata      = c_data;
    ram_re         = 1'b0;
    ram_raddr      = addr;
    load           = 1'b0;
    load_byte      = ram_rdata;
    load_has       = 1'b1;
    load_last      = (remaining == LEN_W'(1));
    load_nseq      = nseq;
    case (state)
      sbrl_pkg::BK_IDLE: begin
        if (!cmd_empty) begin
          if (!c_is_pull) begin
            ram_we  = 1'b1;
            cmd_pop = 1'b1;
          end else if (c_len == '0) begin
            if (out_free) begin
              load      = 1'b1;
              load_byte = '0;
              load_has  = 1'b0;
              load_last = 1'b1;
              load_nseq = c_nseq;
              cmd_pop   = 1'b1;
            end
          end else begin
            addr_next      = c_pos;
            remaining_next = c_len;
            nseq_next      = c_nseq;
            cmd_pop        = 1'b1;
            state_next     = sbrl_pkg::BK_READ;
          end
        end
      end
      sbrl_pkg::BK_READ: begin
        ram_re     = 1'b1;
        addr_next  = (addr == AW'(RING_DEPTH - 1)) ? '0 : addr + AW'(1);
        state_next = sbrl_pkg::BK_DATA;
      end
      sbrl_pkg::BK_DATA: begin
        if (out_free) begin
          load           = 1'b1;
          remaining_next = remaining - LEN_W'(1);
          if (remaining == LEN_W'(1)) begin
            state_next = sbrl_pkg::BK_IDLE;
          end else begin
            // Fetch the following byte while this one moves to the output.
            ram_re    = 1'b1;
            addr_next = (addr == AW'(RING_DEPTH - 1)) ? '0 : addr + AW'(1);
          end
        end
      end
      default: begin
        state_next = sbrl_pkg::BK_IDLE;
      end
    endcase
    out_valid_next = load ? 1'b1 : (pop ? 1'b0 : out_valid);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= sbrl_pkg::BK_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    addr      <= addr_next;
    remaining <= remaining_next;
    nseq      <= nseq_next;
    if (load) begin
      out_byte  <= load_byte;
      has_data  <= load_has;
      last      <= load_last;
      after_seq <= load_nseq;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/sequenced_byte_ring_log_top.sv =====
// Byte trace ring with sequence numbers. Every byte written is numbered by a
// 32-bit count of all bytes written since reset or the last clear; a pull
// names the sequence to resume from and a length limit, and gets back the
// earliest retained bytes from that point, oldest first, one result per
// byte, with the last one flagged and every result carrying the sequence to
// ask for next. A pull with nothing to deliver returns one result with
// has_data low. Items are accepted while full is low and results are read
// while empty is low. The front works out the resume point of each item in
// the cycle it is accepted, holds it one register stage in which the read
// position and length are derived, and passes writes and pulls through a
// four-entry command queue to the back, which owns the ring memory and the
// output register. A write reaches the memory at the edge that takes it
// from the queue. A pull starts by taking the command, then making the
// first memory read, and then delivers its bytes while pop keeps up, as
// the single read port of the ring memory fetches one byte a cycle while
// the output register is free; an empty pull loads its one result as the
// command is taken. Ring memory contents are not cleared by reset or by a
// clear item, and no pull ever reads an entry that has not been written.
`default_nettype none

module sequenced_byte_ring_log_top #(
  parameter int RING_DEPTH = sbrl_pkg::RING_DEPTH_DEF,
  parameter int MAX_PULL   = sbrl_pkg::MAX_PULL_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        push,
  output logic                             full,
  input  wire logic [sbrl_pkg::KIND_W-1:0] kind,
  input  wire logic [sbrl_pkg::BYTE_W-1:0] data_byte,
  input  wire logic [sbrl_pkg::SEQ_W-1:0]  from_seq,
  input  wire logic [sbrl_pkg::LEN_W-1:0]  max_len,
  output logic                             empty,
  input  wire logic                        pop,
  output logic      [sbrl_pkg::BYTE_W-1:0] out_byte,
  output logic                             has_data,
  output logic                             last,
  output logic      [sbrl_pkg::SEQ_W-1:0]  after_seq
);

  // Ring address width and the width of one queued command.
  localparam int AW    = $clog2(RING_DEPTH);
  localparam int CMD_W = 1 + sbrl_pkg::BYTE_W + AW + sbrl_pkg::LEN_W + sbrl_pkg::SEQ_W;

  // Command queue between the front and the back.
  logic             cmd_push;
  logic [CMD_W-1:0] cmd_in;
  logic             cmd_full;
  logic             cmd_pop;
  logic [CMD_W-1:0] cmd_out;
  logic             cmd_empty;

  // Ring memory port.
  logic                        ram_we;
  logic [AW-1:0]               ram_waddr;
  logic [sbrl_pkg::BYTE_W-1:0] ram_wdata;
  logic                        ram_re;
  logic [AW-1:0]               ram_raddr;
  logic [sbrl_pkg::BYTE_W-1:0] ram_rdata;

  // The front keeps the write position and byte count current as items are
  // accepted, so a pull sees exactly the writes accepted before it. Clears
  // take effect in the front alone since they never touch the memory.
  sbrl_front #(
    .RING_DEPTH (RING_DEPTH),
    .MAX_PULL   (MAX_PULL),
    .AW         (AW),
    .CMD_W      (CMD_W)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .kind      (kind),
    .data_byte (data_byte),
    .from_seq  (from_seq),
    .max_len   (max_len),
    .cmd_push  (cmd_push),
    .cmd_data  (cmd_in),
    .cmd_full  (cmd_full)
  );

  // Writes and pulls stay in order through the queue, so a later write can
  // never overwrite a byte that an earlier pull has yet to read.
  sbrl_cmd_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (sbrl_pkg::CMD_DEPTH)
  ) u_cmd_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (cmd_push),
    .din   (cmd_in),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .dout  (cmd_out),
    .empty (cmd_empty)
  );

  // The back executes one command at a time against the ring memory and
  // loads results into the output register.
  sbrl_back #(
    .RING_DEPTH (RING_DEPTH),
    .AW         (AW),
    .CMD_W      (CMD_W)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_empty (cmd_empty),
    .cmd_data  (cmd_out),
    .cmd_pop   (cmd_pop),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .empty     (empty),
    .pop       (pop),
    .out_byte  (out_byte),
    .has_data  (has_data),
    .last      (last),
    .after_seq (after_seq)
  );

  sbrl_ram #(
    .WIDTH (sbrl_pkg::BYTE_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // The front never offers a command to a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(cmd_push && cmd_full))
    else $error("command pushed into a full queue");

  // The back never takes a command from an empty queue.
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(cmd_pop && cmd_empty))
    else $error("command popped from an empty queue");

  // An empty pull result is always the last result of its pull.
  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && !has_data) |-> last)
    else $error("empty pull result without last flag");

  // Memory is never written and read in the same cycle.
  a_ram_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(ram_we && ram_re))
    else $error("ring written and read in the same cycle");

endmodule

`default_nettype wire
